// ===== rtl/core/mfc_pkg.sv =====
// Shared types and constants for the message framer with CRC-16 trailer.
`timescale 1ns / 1ps

package mfc_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRC_POLY            = 1'b0,
    CFG_CRC_HIGH_BYTE_FIRST = 1'b1
  } cfg_idx_e;

  // Input item kinds.
  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_e;

  // CRC constants.
  localparam int unsigned CrcW          = 16;
  localparam logic [CrcW-1:0] CrcInit   = 16'h0000;
  localparam logic [CrcW-1:0] CrcTopBit = 16'h8000;
  localparam logic [CrcW-1:0] CrcMask   = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPolyReset = 16'h8005;
  localparam logic CrcHighByteFirstReset   = 1'b0;

  // Default depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic       is_header;
    logic [7:0] byte0;     // data type, or the payload byte
    logic [7:0] byte1;     // service id
    logic [7:0] byte2;     // command id
    logic       frame_end;
  } entry_t;

  // Front to queue: write side.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  // Queue to back: head of the queue.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

// ===== rtl/core/mfc_if.sv =====
// Valid/ready channel interfaces for the framer input items and output bytes.
`timescale 1ns / 1ps

interface mfc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_type;
  logic [7:0] service_id;
  logic [7:0] command_id;
  logic [7:0] payload_byte;
  logic       frame_end;

  modport source (
    output valid, cmd, data_type, service_id, command_id, payload_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_type, service_id, command_id, payload_byte, frame_end,
    output ready
  );
endinterface

interface mfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (
    output valid, out_byte, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_last,
    output ready
  );
endinterface

// ===== rtl/core/mfc_front.sv =====
// Front end: accepts input items, tracks the open frame and queues valid work.
`timescale 1ns / 1ps

module mfc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfc_in_if.sink        in_i,
  input  logic          q_full_i,
  output mfc_pkg::q_wr_t q_wr_o
);
  import mfc_pkg::*;

  logic in_frame_q, in_frame_d;
  logic accept;
  logic is_header;

  assign in_i.ready = ~q_full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign is_header  = (in_i.cmd == CMD_HEADER);

  // Payload bytes outside a frame are dropped here and never reach the back.
  always_comb begin
    q_wr_o.push            = accept & (is_header | in_frame_q);
    q_wr_o.entry.is_header = is_header;
    q_wr_o.entry.byte0     = is_header ? in_i.data_type : in_i.payload_byte;
    q_wr_o.entry.byte1     = in_i.service_id;
    q_wr_o.entry.byte2     = in_i.command_id;
    q_wr_o.entry.frame_end = in_i.frame_end;

    in_frame_d = in_frame_q;
    if (accept) begin
      if (is_header) begin
        in_frame_d = ~in_i.frame_end;
      end else if (in_frame_q && in_i.frame_end) begin
        in_frame_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// ===== rtl/core/mfc_queue.sv =====
// Short FIFO of classified items between the front and the back.
`timescale 1ns / 1ps

module mfc_queue #(
  parameter int unsigned Depth = mfc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfc_pkg::q_wr_t    q_wr_i,
  output logic              q_full_o,
  output mfc_pkg::q_head_t  q_head_o,
  input  logic              q_pop_i
);
  import mfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign q_full_o       = (count_q == CntW'(Depth));
  assign q_head_o.valid = (count_q != '0);
  assign q_head_o.entry = entries_q[rd_ptr_q];

  assign do_push = q_wr_i.push & ~q_full_o;
  assign do_pop  = q_pop_i & q_head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

  // The front never pushes into a full queue, since its ready follows full.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_i.push |-> !q_full_o)
    else $error("queue: push while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue: fill count out of range");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue: fill count did not follow a push");

endmodule

// ===== rtl/core/mfc_back.sv =====
// Back end: emits the message bytes, folds them into the CRC, appends the trailer.
`timescale 1ns / 1ps

module mfc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mfc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  mfc_pkg::q_head_t                q_head_i,
  output logic                            q_pop_o,
  mfc_out_if.source                       out_o
);
  import mfc_pkg::*;

  // One byte folded into the CRC, MSB first.
  function automatic logic [CrcW-1:0] fold_byte(input logic [CrcW-1:0] crc,
                                                input logic [7:0]      data,
                                                input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTopBit) != CrcInit) begin
        c = ((c << 1) ^ poly) & CrcMask;
      end else begin
        c = (c << 1) & CrcMask;
      end
    end
    return c;
  endfunction

  logic [CrcW-1:0] poly_q;
  logic            hbf_q;
  logic [CrcW-1:0] crc_q, crc_d;
  logic [2:0]      step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  logic       advance, emit;
  logic [2:0] n_content, last_step;
  logic       is_content, is_trailer_first, is_final;
  logic [7:0] content_byte;
  logic [7:0] crc_lo, crc_hi;
  logic [CrcW-1:0] crc_base;
  entry_t     e;

  assign e         = q_head_i.entry;
  assign advance   = ~out_valid_q | out_o.ready;
  assign emit      = advance & q_head_i.valid;

  assign n_content        = e.is_header ? 3'd3 : 3'd1;
  assign last_step        = e.frame_end ? n_content + 3'd1 : n_content - 3'd1;
  assign is_content       = (step_q < n_content);
  assign is_trailer_first = (step_q == n_content);
  assign is_final         = (step_q == last_step);
  assign crc_lo           = crc_q[7:0];
  assign crc_hi           = crc_q[15:8];

  always_comb begin
    case (step_q)
      3'd1:    content_byte = e.byte1;
      3'd2:    content_byte = e.byte2;
      default: content_byte = e.byte0;
    endcase
  end

  // A header restarts the CRC on its first byte.
  assign crc_base = (e.is_header && step_q == 3'd0) ? CrcInit : crc_q;

  always_comb begin
    step_d      = step_q;
    crc_d       = crc_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;

    if (advance) begin
      out_valid_d = q_head_i.valid;
    end

    if (emit) begin
      if (is_content) begin
        out_byte_d = content_byte;
        out_last_d = 1'b0;
        crc_d      = fold_byte(crc_base, content_byte, poly_q);
      end else if (is_trailer_first) begin
        out_byte_d = hbf_q ? crc_hi : crc_lo;
        out_last_d = 1'b0;
      end else begin
        out_byte_d = hbf_q ? crc_lo : crc_hi;
        out_last_d = 1'b1;
        crc_d      = CrcInit;
      end

      if (is_final) begin
        step_d  = 3'd0;
        q_pop_o = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q      <= CrcPolyReset;
      hbf_q       <= CrcHighByteFirstReset;
      crc_q       <= CrcInit;
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CRC_POLY:            poly_q <= cfg_wdata_i;
          CFG_CRC_HIGH_BYTE_FIRST: hbf_q  <= cfg_wdata_i[0];
          default:                 ;
        endcase
      end
      crc_q       <= crc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 3'd4)
    else $error("back: byte step out of range");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last_d) |=> (step_q == 3'd0 && crc_q == CrcInit))
    else $error("back: frame end did not restart the sequencer");

  a_pop_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (emit && is_final))
    else $error("back: queue popped outside the final byte of an item");

endmodule

// ===== rtl/core/message_framer_crc16.sv =====
// Top level of the message framer that appends a CRC-16 trailer to each frame.
`timescale 1ns / 1ps

// Usage:
// Items arrive on the in_i channel and framed bytes leave on out_o, both as
// valid/ready channels; a transfer happens on a clock edge where both are high.
// A header item produces three bytes (data type, service id, command id) and
// restarts the CRC. A payload item inside a frame produces its byte; one outside
// a frame is dropped. An item with frame_end adds two CRC bytes, the second one
// marked with out_last. The byte order comes from the crc_high_byte_first
// register, the polynomial from crc_poly; write them only while the block idles.
// The first byte of an item passes the queue entry and then the output register
// when the queue is empty. Output runs at one byte per cycle while the receiver
// is ready, set by the single byte sequencer in the back end, so payload items
// are taken one per cycle; a header or a trailer holds input once the queue fills.
// The front and the back are separated by a small queue (QueueDepth entries).
// Reset clears the CRC, closes any frame, empties the queue and loads the
// register defaults (polynomial 0x8005, low byte first).
// When the receiver stalls, the output register holds its byte, the queue
// fills, and then in_i.ready drops until the receiver takes bytes again.

module message_framer_crc16 #(
  parameter int unsigned QueueDepth = mfc_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mfc_pkg::CfgDataW-1:0] cfg_wdata_i,
  mfc_in_if.sink                       in_i,
  mfc_out_if.source                    out_o
);
  import mfc_pkg::*;

  q_wr_t   q_wr;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Front end: handshake, frame tracking and dropping of stray payload.
  mfc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  // Queue decouples input acceptance from byte emission.
  mfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .q_full_o (q_full),
    .q_head_o (q_head),
    .q_pop_i  (q_pop)
  );

  // Back end: byte sequencer, CRC, trailer and the output register.
  mfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule
